>>> rtl/core/mi3_pkg.sv
// Package for the 3x3 fixed-point matrix inverse: widths, types, cofactor index tables.
// Depends on nothing; imported by every module under rtl/core.
`timescale 1ns / 1ps
package mi3_pkg;
	localparam int W      = 32;            // element width
	localparam int F      = 16;            // fraction bits
	localparam int N_EL   = 9;
	localparam int PROD_W = 2 * W;         // element product
	localparam int COF_W  = 2 * W + 1;     // cofactor
	localparam int PP_W   = 2 * W + 1;     // determinant partial product
	localparam int DET_W  = 3 * W + 4;     // determinant, signed
	localparam int MAG_W  = DET_W;         // divider remainder
	localparam int NUM_W  = COF_W + 2 * F; // scaled numerator magnitude
	localparam int Q_W    = W + 1;         // quotient bits resolved by the cell chain
	localparam int HI_W   = NUM_W - Q_W;   // numerator bits above the quotient window
	localparam int IDX_W  = 4;

	typedef logic signed [W-1:0]     elem_t;
	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic signed [DET_W-1:0] det_t;

	// One divider lane (one inverse element in flight).
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [Q_W-1:0]   lo;
		logic [Q_W-1:0]   q;
		logic             neg;
		logic             big;
	} mi3_lane_t;

	// Values shared by all nine lanes of one item.
	typedef struct packed {
		logic [MAG_W-1:0] dmag;
		logic             singular;
	} mi3_ctl_t;

	typedef logic [IDX_W-1:0] idx_t;

	// Cofactor c[i] = m[A]*m[B] - m[E]*m[G]
	localparam idx_t CF_A [N_EL] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
	localparam idx_t CF_B [N_EL] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
	localparam idx_t CF_E [N_EL] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
	localparam idx_t CF_G [N_EL] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
endpackage

>>> rtl/core/mi3_front.sv
// Front pipeline: products, cofactors and the determinant over six stages.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_front
	import mi3_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  elem_t in_m [N_EL],
	output logic  out_valid,
	output cof_t  out_cof [N_EL],
	output det_t  out_det
);
	logic [5:0] vld_q;
	elem_t m_s1 [N_EL];
	logic signed [PROD_W-1:0] pa_s2 [N_EL];
	logic signed [PROD_W-1:0] pb_s2 [N_EL];
	elem_t r_s2 [3];
	cof_t cof_s3 [N_EL];
	elem_t r_s3 [3];
	cof_t cof_s4 [N_EL];
	logic signed [PP_W-1:0] ph_s4 [3];
	logic signed [PP_W-1:0] pl_s4 [3];
	cof_t cof_s5 [N_EL];
	det_t term_s5 [3];
	cof_t cof_s6 [N_EL];
	det_t det_s6;
	cof_t pick [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	// Cofactors feeding the first-row expansion.
	assign pick[0] = cof_s3[0];
	assign pick[1] = cof_s3[3];
	assign pick[2] = cof_s3[6];

	always_ff @(posedge clk) begin
		m_s1 <= in_m;
		for (int i = 0; i < N_EL; i++) begin
			pa_s2[i] <= PROD_W'(m_s1[CF_A[i]]) * PROD_W'(m_s1[CF_B[i]]);
			pb_s2[i] <= PROD_W'(m_s1[CF_E[i]]) * PROD_W'(m_s1[CF_G[i]]);
			cof_s3[i] <= COF_W'(pa_s2[i]) - COF_W'(pb_s2[i]);
		end
		for (int j = 0; j < 3; j++) begin
			r_s2[j] <= m_s1[j];
			r_s3[j] <= r_s2[j];
			// split the cofactor: signed high part, unsigned low word
			ph_s4[j] <= PP_W'(r_s3[j]) * PP_W'(signed'(pick[j][COF_W-1:W]));
			pl_s4[j] <= PP_W'(r_s3[j]) * PP_W'(signed'({1'b0, pick[j][W-1:0]}));
			term_s5[j] <= (DET_W'(ph_s4[j]) <<< W) + DET_W'(pl_s4[j]);
		end
		cof_s4 <= cof_s3;
		cof_s5 <= cof_s4;
		cof_s6 <= cof_s5;
		det_s6 <= term_s5[0] + term_s5[1] + term_s5[2];
	end

	assign out_valid = vld_q[5];
	assign out_cof   = cof_s6;
	assign out_det   = det_s6;
endmodule

>>> rtl/core/mi3_prep.sv
// Divider setup: magnitudes, signs, singular test, scaling and range pre-check.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_prep
	import mi3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  cof_t      in_cof [N_EL],
	input  det_t      in_det,
	output logic      out_valid,
	output mi3_lane_t out_lane [N_EL],
	output mi3_ctl_t  out_ctl
);
	logic [1:0] vld_q;
	logic [COF_W-1:0] mag_s7 [N_EL];
	logic neg_s7 [N_EL];
	mi3_ctl_t ctl_s7;
	mi3_ctl_t ctl_s8;
	mi3_lane_t lane_s8 [N_EL];
	logic [NUM_W-1:0] num [N_EL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[0], in_valid};
		end
	end

	always_comb begin
		for (int i = 0; i < N_EL; i++) begin
			num[i] = NUM_W'(mag_s7[i]) << (2 * F);
		end
	end

	always_ff @(posedge clk) begin
		ctl_s7.dmag     <= in_det[DET_W-1] ? MAG_W'(-in_det) : MAG_W'(in_det);
		ctl_s7.singular <= (in_det == '0);
		for (int i = 0; i < N_EL; i++) begin
			mag_s7[i] <= in_cof[i][COF_W-1] ? COF_W'(-in_cof[i]) : COF_W'(in_cof[i]);
			neg_s7[i] <= in_cof[i][COF_W-1] ^ in_det[DET_W-1];
		end
		ctl_s8 <= ctl_s7;
		for (int i = 0; i < N_EL; i++) begin
			lane_s8[i].rem <= MAG_W'(num[i][NUM_W-1:Q_W]);
			lane_s8[i].lo  <= num[i][Q_W-1:0];
			lane_s8[i].q   <= '0;
			lane_s8[i].neg <= neg_s7[i];
			// quotient already past the cell window: saturate later
			lane_s8[i].big <= (MAG_W'(num[i][NUM_W-1:Q_W]) >= ctl_s7.dmag);
		end
	end

	assign out_valid = vld_q[1];
	assign out_lane  = lane_s8;
	assign out_ctl   = ctl_s8;
endmodule

>>> rtl/core/mi3_div_cell.sv
// One restoring-division cell: resolves one quotient bit for all nine lanes.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_div_cell
	import mi3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  mi3_lane_t in_lane [N_EL],
	input  mi3_ctl_t  in_ctl,
	output logic      out_valid,
	output mi3_lane_t out_lane [N_EL],
	output mi3_ctl_t  out_ctl
);
	logic      vld_q;
	mi3_lane_t lane_q [N_EL];
	mi3_ctl_t  ctl_q;
	logic [MAG_W-1:0] sh [N_EL];
	logic ge [N_EL];

	always_comb begin
		for (int i = 0; i < N_EL; i++) begin
			sh[i] = {in_lane[i].rem[MAG_W-2:0], in_lane[i].lo[Q_W-1]};
			ge[i] = (sh[i] >= in_ctl.dmag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_q <= in_ctl;
		for (int i = 0; i < N_EL; i++) begin
			lane_q[i].rem <= ge[i] ? sh[i] - in_ctl.dmag : sh[i];
			lane_q[i].lo  <= {in_lane[i].lo[Q_W-2:0], 1'b0};
			lane_q[i].q   <= {in_lane[i].q[Q_W-2:0], ge[i]};
			lane_q[i].neg <= in_lane[i].neg;
			lane_q[i].big <= in_lane[i].big;
		end
	end

	assign out_valid = vld_q;
	assign out_lane  = lane_q;
	assign out_ctl   = ctl_q;
endmodule

>>> rtl/core/mi3_out.sv
// Output stage: sign, saturation, singular override and the result register.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_out
	import mi3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  mi3_lane_t in_lane [N_EL],
	input  mi3_ctl_t  in_ctl,
	output logic      out_valid,
	output elem_t     out_el [N_EL],
	output logic      out_singular,
	output logic      out_overflow
);
	logic  vld_q;
	elem_t el_q [N_EL];
	logic  sing_q;
	logic  ovf_q;
	elem_t v [N_EL];
	logic  sat [N_EL];
	logic  any_sat;

	always_comb begin
		any_sat = 1'b0;
		for (int i = 0; i < N_EL; i++) begin
			if (in_lane[i].neg) begin
				sat[i] = in_lane[i].big
					|| (in_lane[i].q > (Q_W'(1) << (W - 1)));
				v[i] = sat[i] ? elem_t'({1'b1, {(W-1){1'b0}}}) : elem_t'(-in_lane[i].q[W-1:0]);
			end else begin
				sat[i] = in_lane[i].big || (in_lane[i].q[Q_W-1:W-1] != '0);
				v[i] = sat[i] ? elem_t'({1'b0, {(W-1){1'b1}}}) : elem_t'(in_lane[i].q[W-1:0]);
			end
			if (in_ctl.singular) begin
				v[i] = '0;
			end
			any_sat = any_sat | sat[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		el_q   <= v;
		sing_q <= in_ctl.singular;
		ovf_q  <= any_sat & ~in_ctl.singular;
	end

	assign out_valid    = vld_q;
	assign out_el       = el_q;
	assign out_singular = sing_q;
	assign out_overflow = ovf_q;
endmodule

>>> rtl/core/matrix_inverse_3x3.sv
// 3x3 signed Q16.16 matrix inverse by the adjugate.
// Depends on mi3_pkg, mi3_front, mi3_prep, mi3_div_cell, mi3_out.
//
// Usage:
//  - Input channel: drive the nine elements in_r0c0..in_r2c2 (row-major) and
//    raise start; the item is taken at the clock edge where start is high and
//    busy is low. busy stays low: a new item may be taken on every cycle.
//  - Result channel: done is high for exactly one cycle with out_r0c0..out_r2c2,
//    singular and overflow valid in that cycle. The receiver cannot stall, so
//    it must capture the result in that cycle.
//  - Pipeline: products, cofactors and determinant, then divider setup, then
//    33 division cells (one quotient bit each, per lane) and one output register.
//  - Throughput: one item per cycle; the chain of division cells is fully
//    pipelined, one item in each cell.
//  - Singular matrix (determinant zero): all outputs zero, singular high.
//  - Quotients outside the Q16.16 range saturate and set overflow.
//  - Reset (arst_n low) drops every item in flight; no done follows.
`timescale 1ns / 1ps
module matrix_inverse_3x3
	import mi3_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  elem_t in_r0c0,
	input  elem_t in_r0c1,
	input  elem_t in_r0c2,
	input  elem_t in_r1c0,
	input  elem_t in_r1c1,
	input  elem_t in_r1c2,
	input  elem_t in_r2c0,
	input  elem_t in_r2c1,
	input  elem_t in_r2c2,
	output logic  done,
	output elem_t out_r0c0,
	output elem_t out_r0c1,
	output elem_t out_r0c2,
	output elem_t out_r1c0,
	output elem_t out_r1c1,
	output elem_t out_r1c2,
	output elem_t out_r2c0,
	output elem_t out_r2c1,
	output elem_t out_r2c2,
	output logic  singular,
	output logic  overflow
);
	elem_t m [N_EL];
	logic  acc;
	logic  fr_valid;
	cof_t  fr_cof [N_EL];
	det_t  fr_det;
	logic      ch_valid [Q_W+1];
	mi3_lane_t ch_lane  [Q_W+1][N_EL];
	mi3_ctl_t  ch_ctl   [Q_W+1];
	elem_t res [N_EL];

	// Fully pipelined: never hold off the sender.
	assign busy = 1'b0;
	assign acc  = start & ~busy;

	assign m[0] = in_r0c0;
	assign m[1] = in_r0c1;
	assign m[2] = in_r0c2;
	assign m[3] = in_r1c0;
	assign m[4] = in_r1c1;
	assign m[5] = in_r1c2;
	assign m[6] = in_r2c0;
	assign m[7] = in_r2c1;
	assign m[8] = in_r2c2;

	// Products, cofactors and the determinant.
	mi3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (acc),
		.in_m     (m),
		.out_valid(fr_valid),
		.out_cof  (fr_cof),
		.out_det  (fr_det)
	);

	// Magnitudes, signs, singular flag; loads the head of the cell chain.
	mi3_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_cof   (fr_cof),
		.in_det   (fr_det),
		.out_valid(ch_valid[0]),
		.out_lane (ch_lane[0]),
		.out_ctl  (ch_ctl[0])
	);

	// Chain of division cells; cell k resolves quotient bit Q_W-1-k.
	for (genvar k = 0; k < Q_W; k++) begin : g_cell
		mi3_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (ch_valid[k]),
			.in_lane  (ch_lane[k]),
			.in_ctl   (ch_ctl[k]),
			.out_valid(ch_valid[k+1]),
			.out_lane (ch_lane[k+1]),
			.out_ctl  (ch_ctl[k+1])
		);
	end

	// Saturate, apply the singular override, register the result.
	mi3_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (ch_valid[Q_W]),
		.in_lane     (ch_lane[Q_W]),
		.in_ctl      (ch_ctl[Q_W]),
		.out_valid   (done),
		.out_el      (res),
		.out_singular(singular),
		.out_overflow(overflow)
	);

	assign out_r0c0 = res[0];
	assign out_r0c1 = res[1];
	assign out_r0c2 = res[2];
	assign out_r1c0 = res[3];
	assign out_r1c1 = res[4];
	assign out_r1c2 = res[5];
	assign out_r2c0 = res[6];
	assign out_r2c1 = res[7];
	assign out_r2c2 = res[8];
endmodule

>>> bench/tb_matrix_inverse_3x3.sv
// Testbench for matrix_inverse_3x3: drives random and directed 3x3 Q16.16 matrices,
// predicts each inverse by exact wide-integer adjugate division, checks every done item.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
`timescale 1ns / 1ps

typedef logic signed [31:0] q16_t;

typedef struct {
	q16_t el[9];
	logic singular;
	logic overflow;
} inverse_t;

class inverse_scoreboard;
	inverse_t pending[$];
	int unsigned mismatches;

	// Exact inverse: cofactor * 2^32 / det, truncated toward zero, saturated.
	function automatic inverse_t predict_inverse(q16_t m[9]);
		inverse_t r;
		logic signed [255:0] mw[9];
		logic signed [255:0] cof[9];
		logic signed [255:0] det;
		logic signed [255:0] quot;
		logic signed [255:0] lim_pos;
		logic signed [255:0] lim_neg;
		for (int i = 0; i < 9; i++) mw[i] = m[i];
		cof[0] = mw[4]*mw[8] - mw[5]*mw[7];
		cof[1] = mw[2]*mw[7] - mw[1]*mw[8];
		cof[2] = mw[1]*mw[5] - mw[2]*mw[4];
		cof[3] = mw[5]*mw[6] - mw[3]*mw[8];
		cof[4] = mw[0]*mw[8] - mw[2]*mw[6];
		cof[5] = mw[2]*mw[3] - mw[0]*mw[5];
		cof[6] = mw[3]*mw[7] - mw[4]*mw[6];
		cof[7] = mw[1]*mw[6] - mw[0]*mw[7];
		cof[8] = mw[0]*mw[4] - mw[1]*mw[3];
		det = mw[0]*cof[0] + mw[1]*cof[3] + mw[2]*cof[6];
		r.singular = (det == 0);
		r.overflow = 1'b0;
		lim_pos = 256'sd2147483647;
		lim_neg = -256'sd2147483648;
		for (int i = 0; i < 9; i++) begin
			if (r.singular) begin
				r.el[i] = '0;
			end else begin
				// signed / truncates toward zero
				quot = (cof[i] <<< 32) / det;
				if (quot > lim_pos) begin
					quot = lim_pos;
					r.overflow = 1'b1;
				end else if (quot < lim_neg) begin
					quot = lim_neg;
					r.overflow = 1'b1;
				end
				r.el[i] = quot[31:0];
			end
		end
		return r;
	endfunction

	function void note_matrix(q16_t m[9]);
		pending.insert(pending.size(), predict_inverse(m));
	endfunction

	function void check_inverse(inverse_t got);
		inverse_t want;
		bit bad;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
			return;
		end
		want = pending.pop_front();
		bad = (got.singular !== want.singular) || (got.overflow !== want.overflow);
		for (int i = 0; i < 9; i++) if (got.el[i] !== want.el[i]) bad = 1;
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch at %0t: sing %b/%b ovf %b/%b (exp/act)", $realtime,
					want.singular, got.singular, want.overflow, got.overflow);
				for (int i = 0; i < 9; i++)
					$display("  el%0d exp %h act %h", i, want.el[i], got.el[i]);
			end
		end
	endfunction
endclass

module tb_matrix_inverse_3x3;
	import mi3_pkg::*;

	localparam int LATENCY = 42;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic singular;
	logic overflow;
	elem_t in_el[9];
	elem_t out_el[9];

	inverse_scoreboard inv_board;
	int send_idle_pct;

	matrix_inverse_3x3 u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_r0c0(in_el[0]), .in_r0c1(in_el[1]), .in_r0c2(in_el[2]),
		.in_r1c0(in_el[3]), .in_r1c1(in_el[4]), .in_r1c2(in_el[5]),
		.in_r2c0(in_el[6]), .in_r2c1(in_el[7]), .in_r2c2(in_el[8]),
		.done(done),
		.out_r0c0(out_el[0]), .out_r0c1(out_el[1]), .out_r0c2(out_el[2]),
		.out_r1c0(out_el[3]), .out_r1c1(out_el[4]), .out_r1c2(out_el[5]),
		.out_r2c0(out_el[6]), .out_r2c1(out_el[7]), .out_r2c2(out_el[8]),
		.singular(singular), .overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: far beyond 1712 items with idling plus pipeline latency.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Sample results at the rising edge; each cycle with done high carries one result.
	always @(posedge clk) begin
		inverse_t got;
		if (arst_n && done) begin
			for (int i = 0; i < 9; i++) got.el[i] = out_el[i];
			got.singular = singular;
			got.overflow = overflow;
			inv_board.check_inverse(got);
		end
	end

	// Present one matrix at the falling edge, hold start until accepted, then
	// lower start only if the next item does not follow at once.
	task automatic send_matrix(q16_t m[9]);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		for (int i = 0; i < 9; i++) in_el[i] <= m[i];
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		inv_board.note_matrix(m);
		@(negedge clk);
	endtask

	// Pick an element: mostly moderate Q16.16 values, some extremes and full random.
	function automatic q16_t rand_elem();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			2: return 32'sh10000 * ($urandom_range(8) - 4);
			3: return $signed($urandom_range(255)) - 128;
			default: return $signed($urandom_range(32'h7FFFF)) - 32'sh40000;
		endcase
	endfunction

	task automatic send_random(int count);
		q16_t m[9];
		int k;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++) m[i] = rand_elem();
			// make some rows dependent to hit the singular path
			if ($urandom_range(15) == 0) begin
				k = $urandom_range(2);
				for (int j = 0; j < 3; j++) m[3*k + j] = m[3*((k+1)%3) + j];
			end
			send_matrix(m);
		end
	endtask

	initial begin
		q16_t m[9];
		int waited;
		inv_board = new();
		arst_n = 1'b0;
		start = 1'b0;
		send_idle_pct = 0;
		for (int i = 0; i < 9; i++) in_el[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: identity, diagonal, zero, extremes, tiny det, overflow.
		m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
		send_matrix(m);
		m = '{32'sh20000, 0, 0, 0, -32'sh40000, 0, 0, 0, 32'sh8000};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};
		send_matrix(m);
		m = '{32'sh7FFFFFFF, 0, 0, 0, 32'sh7FFFFFFF, 0, 0, 0, 32'sh7FFFFFFF};
		send_matrix(m);
		m = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
		send_matrix(m);
		m = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		send_matrix(m);
		m = '{32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh5555AAAA, 32'shAAAA5555,
			32'sh0F0F0F0F, 32'shF0F0F0F0, 32'sh33CC33CC, 32'shCC33CC33};
		send_matrix(m);
		m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh20000, 32'sh40000, 32'sh60000,
			1, 2, 3};
		send_matrix(m);
		m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000, 32'sh60000,
			32'sh70000, 32'sh80000, 32'sh90001};
		send_matrix(m);
		m = '{0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, -32'sh10000};
		send_matrix(m);

		// Random: sender idles 30%, then 45%, then not at all.
		send_idle_pct = 30;
		send_random(560);
		send_idle_pct = 45;
		send_random(560);
		send_idle_pct = 0;
		send_random(580);
		start <= 1'b0;

		waited = 0;
		while (inv_board.pending.size() != 0 && waited < 10 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);
		if (inv_board.mismatches == 0 && inv_board.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
